// ===== rtl/core/sle_pkg.sv =====
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types and constants for the serial line editor: character codes,
// the command word passed from the front end to the back end, and the
// result word shown on the output ports.
// ----------------------------------------------------------------------------
package sle_pkg;

  // terminal character codes
  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_ESC   = 8'd27;
  localparam logic [7:0] CH_DEL1  = 8'd126;
  localparam logic [7:0] CH_DEL2  = 8'd127;
  localparam logic [7:0] CH_SPACE = 8'd32;

  // bytes discarded after an escape
  localparam logic [1:0] ESC_SKIP = 2'd2;

  // index reach of the 8-bit line index
  localparam int unsigned INDEX_REACH = 256;

  // command queue between front and back
  localparam int unsigned CMDQ_DEPTH = 4;
  localparam int unsigned CMDQ_PW    = $clog2(CMDQ_DEPTH);

  // erase expands into three words
  localparam logic [1:0] ERASE_PH_BS1   = 2'd0;
  localparam logic [1:0] ERASE_PH_SPACE = 2'd1;
  localparam logic [1:0] ERASE_PH_BS2   = 2'd2;

  typedef enum logic [1:0] {
    CMD_STORE,
    CMD_ERASE,
    CMD_EOL
  } cmd_kind_t;

  // classified word from the front end
  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  data;   // byte to store
    logic [7:0]  index;  // store / erase position, or line length
  } cmd_t;

  // one result word
  typedef struct packed {
    logic        echo_valid;
    logic [7:0]  echo_byte;
    logic        store_valid;
    logic [7:0]  store_index;
    logic [7:0]  store_byte;
    logic        line_done;
    logic [7:0]  line_length;
    logic        last;
  } result_t;

endpackage

// ===== rtl/core/sle_front.sv =====
// ----------------------------------------------------------------------------
// sle_front
// Front end: holds the capacity register, the line index and the escape
// skip count, accepts one received byte per cycle while the command queue
// has room, and queues a command for every byte that produces output.
// ----------------------------------------------------------------------------
module sle_front import sle_pkg::*; #(
  parameter int unsigned MAX_LINE = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [8:0] cfg_line_capacity,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_rx_byte,
  input  logic       q_full,
  output logic       q_push,
  output cmd_t       q_cmd
);

  // capacity ceiling from the build limit and the index reach
  localparam logic [8:0] CAP_LIMIT = (MAX_LINE < INDEX_REACH) ? 9'(MAX_LINE)
                                                              : 9'(INDEX_REACH);

  logic [8:0] capacity_r;
  logic [7:0] line_index_r, line_index_nxt;
  logic [1:0] skip_count_r, skip_count_nxt;
  logic [8:0] eff_cap;
  logic       accept;
  logic       is_erase;

  assign cfg_ready = 1'b1;
  assign in_full   = q_full;
  assign accept    = in_push && !q_full;

  // capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= 9'(INDEX_REACH);
    end else if (cfg_valid) begin
      capacity_r <= cfg_line_capacity;
    end
  end

  assign eff_cap  = (capacity_r > CAP_LIMIT) ? CAP_LIMIT : capacity_r;
  assign is_erase = (in_rx_byte == CH_BS) || (in_rx_byte == CH_DEL1) ||
                    (in_rx_byte == CH_DEL2);

  // classify the byte and work out the next line state
  always_comb begin
    line_index_nxt = line_index_r;
    skip_count_nxt = skip_count_r;
    q_push         = 1'b0;
    q_cmd.kind     = CMD_STORE;
    q_cmd.data     = in_rx_byte;
    q_cmd.index    = line_index_r;
    if (accept) begin
      if (skip_count_r != 2'd0) begin
        skip_count_nxt = skip_count_r - 2'd1;
      end else if (in_rx_byte == CH_CR) begin
        q_push         = 1'b1;
        q_cmd.kind     = CMD_EOL;
        line_index_nxt = 8'd0;
      end else if (is_erase) begin
        if (line_index_r != 8'd0) begin
          q_push         = 1'b1;
          q_cmd.kind     = CMD_ERASE;
          q_cmd.index    = line_index_r - 8'd1;
          line_index_nxt = line_index_r - 8'd1;
        end
      end else if (in_rx_byte == CH_ESC) begin
        skip_count_nxt = ESC_SKIP;
      end else if (({1'b0, line_index_r} + 9'd1) < eff_cap) begin
        q_push         = 1'b1;
        line_index_nxt = line_index_r + 8'd1;
      end
    end
  end

  // line state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_index_r <= 8'd0;
      skip_count_r <= 2'd0;
    end else begin
      line_index_r <= line_index_nxt;
      skip_count_r <= skip_count_nxt;
    end
  end

endmodule

// ===== rtl/core/sle_cmdq.sv =====
// ----------------------------------------------------------------------------
// sle_cmdq
// Short command queue between the front end and the back end, so that an
// erase expanding into three words does not hold up byte intake.
// ----------------------------------------------------------------------------
module sle_cmdq import sle_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t head
);

  cmd_t               slot_r [CMDQ_DEPTH];
  logic [CMDQ_PW-1:0] wr_ptr_r;
  logic [CMDQ_PW-1:0] rd_ptr_r;
  logic [CMDQ_PW:0]   count_r;
  logic               do_push;
  logic               do_pop;

  assign full    = (count_r == (CMDQ_PW+1)'(CMDQ_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slot_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== rtl/core/sle_back.sv =====
// ----------------------------------------------------------------------------
// sle_back
// Back end: turns queued commands into result words and holds each in an
// output register until popped; one word per cycle while the receiver pops.
// ----------------------------------------------------------------------------
module sle_back import sle_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    q_empty,
  input  cmd_t    q_head,
  output logic    q_pop,
  input  logic    out_pop,
  output logic    out_empty,
  output result_t out_word
);

  logic       out_valid_r;
  result_t    word_r, word_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic       load;
  logic       take;

  assign load      = !out_valid_r || out_pop;
  assign take      = load && !q_empty;
  assign out_empty = !out_valid_r;
  assign out_word  = word_r;

  // build the next word from the queue head and the erase phase
  always_comb begin
    word_nxt  = '0;
    phase_nxt = phase_r;
    q_pop     = 1'b0;
    case (q_head.kind)
      CMD_STORE: begin
        word_nxt.echo_valid  = 1'b1;
        word_nxt.echo_byte   = q_head.data;
        word_nxt.store_valid = 1'b1;
        word_nxt.store_index = q_head.index;
        word_nxt.store_byte  = q_head.data;
        word_nxt.last        = 1'b1;
      end
      CMD_EOL: begin
        word_nxt.line_done   = 1'b1;
        word_nxt.line_length = q_head.index;
        word_nxt.last        = 1'b1;
      end
      CMD_ERASE: begin
        word_nxt.echo_valid = 1'b1;
        case (phase_r)
          ERASE_PH_BS1: begin
            word_nxt.echo_byte   = CH_BS;
            word_nxt.store_valid = 1'b1;
            word_nxt.store_index = q_head.index;
          end
          ERASE_PH_SPACE: begin
            word_nxt.echo_byte = CH_SPACE;
          end
          default: begin
            word_nxt.echo_byte = CH_BS;
            word_nxt.last      = 1'b1;
          end
        endcase
      end
      default: begin
        word_nxt = '0;
      end
    endcase
    if (take) begin
      if (q_head.kind == CMD_ERASE && phase_r != ERASE_PH_BS2) begin
        phase_nxt = phase_r + 2'd1;
      end else begin
        phase_nxt = ERASE_PH_BS1;
        q_pop     = 1'b1;
      end
    end
  end

  // output register and erase phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= ERASE_PH_BS1;
    end else begin
      phase_r <= phase_nxt;
      if (load) begin
        out_valid_r <= !q_empty;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      word_r <= word_nxt;
    end
  end

endmodule

// ===== rtl/core/serial_line_editor.sv =====
// ----------------------------------------------------------------------------
// serial_line_editor
// Terminal line discipline with echo: edits a line held in an external
// buffer and answers received bytes with echo, buffer write and
// end-of-line words.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-------------------------------
//   in_     | in        | in_push / in_full   | in_rx_byte
//   out_    | out       | out_pop / out_empty | echo, store, line_done, last
//   cfg_    | in        | cfg_valid/cfg_ready | cfg_line_capacity
//
// One byte is taken per cycle while the four-entry command queue has room.
// Results leave at one word per cycle from the output register while the
// receiver pops; an erase gives three words, other bytes one word or none.
// Reset is synchronous: line index and skip count clear, capacity is 256,
// the queue and output register empty. A missing pop stalls only the back end;
// intake stops only when the command queue is full.
// ----------------------------------------------------------------------------
module serial_line_editor import sle_pkg::*; #(
  parameter int unsigned MAX_LINE = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [8:0] cfg_line_capacity,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_rx_byte,
  output logic       out_empty,
  input  logic       out_pop,
  output logic       out_echo_valid,
  output logic [7:0] out_echo_byte,
  output logic       out_store_valid,
  output logic [7:0] out_store_index,
  output logic [7:0] out_store_byte,
  output logic       out_line_done,
  output logic [7:0] out_line_length,
  output logic       out_last
);

  logic    q_full;
  logic    q_push;
  cmd_t    q_cmd;
  logic    q_empty;
  logic    q_pop;
  cmd_t    q_head;
  result_t word;

  // byte intake and classification
  sle_front #(
    .MAX_LINE (MAX_LINE)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_line_capacity (cfg_line_capacity),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_rx_byte        (in_rx_byte),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_cmd             (q_cmd)
  );

  // command queue
  sle_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  // result generation
  sle_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_word  (word)
  );

  assign out_echo_valid  = word.echo_valid;
  assign out_echo_byte   = word.echo_byte;
  assign out_store_valid = word.store_valid;
  assign out_store_index = word.store_index;
  assign out_store_byte  = word.store_byte;
  assign out_line_done   = word.line_done;
  assign out_line_length = word.line_length;
  assign out_last        = word.last;

endmodule

// ===== rtl/core/sle_checker.sv =====
// ----------------------------------------------------------------------------
// sle_checker
// Port-level checks for the serial line editor, bound to the top level.
// ----------------------------------------------------------------------------
module sle_checker import sle_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_full,
  input logic       out_empty,
  input logic       out_pop,
  input logic       out_echo_valid,
  input logic [7:0] out_echo_byte,
  input logic       out_store_valid,
  input logic [7:0] out_store_byte,
  input logic       out_line_done,
  input logic       out_last
);

  // a waiting word holds while not popped
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_echo_byte) &&
                                  $stable(out_last)))
    else $error("waiting word changed before pop");

  // end of line carries no echo or write and closes the byte
  a_eol: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_line_done) |->
      (!out_echo_valid && !out_store_valid && out_last))
    else $error("end-of-line word malformed");

  // first erase word writes a zero and echoes backspace
  a_erase: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_store_valid && !out_last) |->
      (out_echo_byte == CH_BS && out_store_byte == 8'd0 && !out_line_done))
    else $error("erase word malformed");

  // after reset both sides are clear
  a_reset: assert property (@(posedge clk)
    !rst_n |=> (out_empty && !in_full))
    else $error("not clear after reset");

endmodule

bind serial_line_editor sle_checker u_sle_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_full         (in_full),
  .out_empty       (out_empty),
  .out_pop         (out_pop),
  .out_echo_valid  (out_echo_valid),
  .out_echo_byte   (out_echo_byte),
  .out_store_valid (out_store_valid),
  .out_store_byte  (out_store_byte),
  .out_line_done   (out_line_done),
  .out_last        (out_last)
);

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for serial_line_editor. Terminal bytes go in through
// the push/full port while result words are drawn through the pop/empty
// port, both with random gaps. A line tracker follows the line index, the
// escape skip count and the capacity, predicts every echo, buffer write and
// end-of-line word, and checks each popped word field by field. The run
// walks through several capacities, from zero up to the 9-bit maximum.
// ----------------------------------------------------------------------------
module tb;
  import sle_pkg::*;

  localparam int unsigned MAX_LINE      = 256;
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned GAP_PCT       = 31;
  localparam int unsigned NUM_PHASES    = 10;

  // opening sequence: erase on an empty line, extreme bytes, every erase
  // code, escapes that swallow a carriage return, an erase and an escape
  localparam logic [7:0] OPENING [19] = '{
    CH_BS, CH_DEL1, CH_DEL2, 8'h00, 8'hFF, 8'h41, CH_BS, CH_DEL1, CH_DEL2,
    CH_CR, CH_ESC, CH_CR, CH_BS, 8'h55, CH_ESC, CH_ESC, 8'hAA, 8'h33, CH_CR
  };

  // capacities for the random part, with length and style of each phase
  localparam logic [8:0] PHASE_CAP [NUM_PHASES] = '{
    9'd5, 9'd3, 9'd511, 9'd4, 9'd256, 9'd1, 9'd0, 9'd300, 9'd40, 9'd17
  };
  localparam int unsigned PHASE_LEN [NUM_PHASES] = '{
    15, 12, 52, 15, 25, 8, 8, 15, 20, 15
  };
  localparam bit PHASE_FILL [NUM_PHASES] = '{0, 0, 1, 0, 0, 0, 0, 0, 0, 0};
  localparam bit PHASE_CALM [NUM_PHASES] = '{0, 0, 0, 0, 1, 0, 0, 0, 0, 0};

  // tracks the edited line and holds the words still due
  class line_tracker;
    logic [7:0]  idx;
    logic [1:0]  skip;
    logic [8:0]  cap;
    result_t     due_words[$];
    int unsigned errors, n_bytes, n_words, n_stored, n_erased, n_lines;
    int unsigned n_dropped, n_skipped, n_cfg, longest;

    function new();
      idx  = '0;
      skip = '0;
      cap  = 9'd256;
    endfunction

    function int unsigned room();
      int unsigned c;
      c = cap;
      if (c > MAX_LINE) c = MAX_LINE;
      if (c > INDEX_REACH) c = INDEX_REACH;
      return c;
    endfunction

    function int unsigned pending();
      return due_words.size();
    endfunction

    // predict the words caused by one accepted byte
    function void take_byte(logic [7:0] b);
      result_t w;
      n_bytes++;
      if (skip != 0) begin
        skip = skip - 2'd1;
        n_skipped++;
        return;
      end
      w = '0;
      if (b == CH_CR) begin
        w.line_done   = 1'b1;
        w.line_length = idx;
        w.last        = 1'b1;
        due_words.push_back(w);
        idx = '0;
        n_lines++;
      end else if (b == CH_BS || b == CH_DEL1 || b == CH_DEL2) begin
        // erase expands to backspace, space, backspace
        if (idx != 0) begin
          idx           = idx - 8'd1;
          w.echo_valid  = 1'b1;
          w.echo_byte   = CH_BS;
          w.store_valid = 1'b1;
          w.store_index = idx;
          due_words.push_back(w);
          w             = '0;
          w.echo_valid  = 1'b1;
          w.echo_byte   = CH_SPACE;
          due_words.push_back(w);
          w.echo_byte   = CH_BS;
          w.last        = 1'b1;
          due_words.push_back(w);
          n_erased++;
        end
      end else if (b == CH_ESC) begin
        skip = ESC_SKIP;
      end else if (int'(idx) + 1 < room()) begin
        w.echo_valid  = 1'b1;
        w.echo_byte   = b;
        w.store_valid = 1'b1;
        w.store_index = idx;
        w.store_byte  = b;
        w.last        = 1'b1;
        due_words.push_back(w);
        idx = idx + 8'd1;
        n_stored++;
        if (idx > longest) longest = idx;
      end else begin
        n_dropped++;
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("tb: mismatch: %s", msg);
    endtask

    // compare one popped word with the oldest one due
    task match_word(result_t got);
      result_t exp;
      string   diffs;
      n_words++;
      if (due_words.size() == 0) begin
        report($sformatf("unexpected word %h", got));
        return;
      end
      exp   = due_words.pop_front();
      diffs = "";
      if (got.echo_valid  !== exp.echo_valid)  diffs = {diffs, " echo_valid"};
      if (got.echo_byte   !== exp.echo_byte)   diffs = {diffs, " echo_byte"};
      if (got.store_valid !== exp.store_valid) diffs = {diffs, " store_valid"};
      if (got.store_index !== exp.store_index) diffs = {diffs, " store_index"};
      if (got.store_byte  !== exp.store_byte)  diffs = {diffs, " store_byte"};
      if (got.line_done   !== exp.line_done)   diffs = {diffs, " line_done"};
      if (got.line_length !== exp.line_length) diffs = {diffs, " line_length"};
      if (got.last        !== exp.last)        diffs = {diffs, " last"};
      if (diffs != "")
        report($sformatf("word %0d got %h want %h, wrong:%s", n_words, got, exp, diffs));
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [8:0] cfg_line_capacity = '0;
  logic       in_push = 1'b0;
  logic       in_full;
  logic [7:0] in_rx_byte = '0;
  logic       out_empty;
  logic       out_pop = 1'b0;
  logic       out_echo_valid;
  logic [7:0] out_echo_byte;
  logic       out_store_valid;
  logic [7:0] out_store_index;
  logic [7:0] out_store_byte;
  logic       out_line_done;
  logic [7:0] out_line_length;
  logic       out_last;

  line_tracker board;
  bit          calm = 1'b0;
  int unsigned cycle_count = 0;
  result_t     seen;

  serial_line_editor #(.MAX_LINE(MAX_LINE)) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_line_capacity (cfg_line_capacity),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_rx_byte        (in_rx_byte),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_echo_valid    (out_echo_valid),
    .out_echo_byte     (out_echo_byte),
    .out_store_valid   (out_store_valid),
    .out_store_index   (out_store_index),
    .out_store_byte    (out_store_byte),
    .out_line_done     (out_line_done),
    .out_line_length   (out_line_length),
    .out_last          (out_last)
  );

  always #10 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver stalls at random except in calm stretches
  always @(posedge clk) begin
    out_pop <= calm || ($urandom_range(0, 99) >= GAP_PCT);
  end

  // sample popped words mid-cycle, where nothing is changing
  always @(negedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      seen.echo_valid  = out_echo_valid;
      seen.echo_byte   = out_echo_byte;
      seen.store_valid = out_store_valid;
      seen.store_index = out_store_index;
      seen.store_byte  = out_store_byte;
      seen.line_done   = out_line_done;
      seen.line_length = out_line_length;
      seen.last        = out_last;
      board.match_word(seen);
    end
  end

  // mostly printable text, with erases, escapes, line ends and raw bytes
  function automatic logic [7:0] pick_byte(bit fill);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (fill) return 8'($urandom_range(32, 125));
    if (r < 8) return CH_CR;
    if (r < 18) begin
      case ($urandom_range(0, 2))
        0: return CH_BS;
        1: return CH_DEL1;
        default: return CH_DEL2;
      endcase
    end
    if (r < 23) return CH_ESC;
    if (r < 45) return 8'($urandom);
    return 8'($urandom_range(32, 125));
  endfunction

  // offer one byte on the input side, with random gaps before it
  task automatic push_byte(logic [7:0] b);
    bit ok;
    while (!calm && $urandom_range(0, 99) < GAP_PCT) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push    <= 1'b1;
    in_rx_byte <= b;
    do begin
      @(negedge clk);
      ok = !in_full;
      @(posedge clk);
    end while (!ok);
    board.take_byte(b);
  endtask

  // hold off until every word due has come and the block is quiet
  task automatic settle();
    in_push <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(logic [8:0] v);
    bit ok;
    cfg_valid         <= 1'b1;
    cfg_line_capacity <= v;
    do begin
      @(negedge clk);
      ok = cfg_ready;
      @(posedge clk);
    end while (!ok);
    cfg_valid <= 1'b0;
    board.cap = v;
    board.n_cfg++;
  endtask

  initial begin
    board = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // opening sequence at the reset capacity
    foreach (OPENING[i]) push_byte(OPENING[i]);

    // smallest useful line, then a capacity that stores nothing
    settle();
    write_capacity(9'd2);
    push_byte(8'h10);
    push_byte(8'h11);
    push_byte(CH_CR);
    settle();
    write_capacity(9'd0);
    push_byte(8'h41);
    push_byte(CH_BS);
    push_byte(CH_CR);

    // random phases; the fill phase leaves a long line behind, which
    // the next phase meets with a capacity far below its index
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      write_capacity(PHASE_CAP[p]);
      calm <= PHASE_CALM[p];
      for (int k = 0; k < PHASE_LEN[p]; k++) push_byte(pick_byte(PHASE_FILL[p]));
    end

    settle();
    $display("tb: %0d bytes in, %0d words checked over %0d capacity settings",
             board.n_bytes, board.n_words, board.n_cfg);
    $display("tb: %0d stored, %0d erased, %0d lines, %0d dropped, %0d skipped, longest %0d",
             board.n_stored, board.n_erased, board.n_lines, board.n_dropped,
             board.n_skipped, board.longest);
    if (board.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/sle_pkg.sv
rtl/core/sle_front.sv
rtl/core/sle_cmdq.sv
rtl/core/sle_back.sv
rtl/core/serial_line_editor.sv
rtl/core/sle_checker.sv
test/tb.sv
